FILE: rtl/rms_pkg.sv
package rms_pkg;

  localparam int unsigned Leaves   = 1024;
  localparam int unsigned LeafBits = (Leaves > 1) ? $clog2(Leaves) : 1;
  localparam int unsigned LeafBase = 1 << LeafBits;
  // node index 1 .. 2*LeafBase-1, node 0 unused
  localparam int unsigned NodeBits = LeafBits + 1;
  // span bounds reach 2*LeafBase
  localparam int unsigned IdxW     = LeafBits + 2;
  localparam int unsigned ValW     = 50;
  localparam int unsigned PosW     = 10;
  localparam int unsigned RangeW   = 11;

  typedef logic [ValW-1:0]     val_t;
  typedef logic [NodeBits-1:0] node_t;
  typedef logic [IdxW-1:0]     idx_t;

  localparam val_t Sentinel = 50'd1000000000000000;

  typedef struct packed {
    logic  we;
    node_t waddr;
    val_t  wdata;
    node_t raddr_a;
    node_t raddr_b;
  } mem_req_t;

  function automatic val_t min_val(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: rtl/rms_node_store.sv
module rms_node_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rms_pkg::mem_req_t req_i,
  output rms_pkg::val_t     rd_a_o,
  output rms_pkg::val_t     rd_b_o,
  output logic              clr_done_o
);
  import rms_pkg::*;

  localparam int unsigned Depth = 1 << NodeBits;

  val_t  mem [Depth];
  val_t  rd_a_q, rd_b_q;
  node_t clr_cnt_q, clr_cnt_d;
  logic  clr_done_q, clr_done_d;

  // sweep every entry to the sentinel once after reset
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + node_t'(1);
      if (clr_cnt_q == node_t'(Depth - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_done_q <= clr_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_done_q) begin
      mem[clr_cnt_q] <= Sentinel;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.raddr_a];
    rd_b_q <= mem[req_i.raddr_b];
  end

  assign rd_a_o     = rd_a_q;
  assign rd_b_o     = rd_b_q;
  assign clr_done_o = clr_done_q;

endmodule

FILE: rtl/rms_ctrl.sv
module rms_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [rms_pkg::PosW-1:0]     position_i,
  input  logic [rms_pkg::ValW-1:0]     value_i,
  input  logic [rms_pkg::RangeW-1:0]   range_start_i,
  input  logic [rms_pkg::RangeW-1:0]   range_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rms_pkg::ValW-1:0]     minimum_o,
  output rms_pkg::mem_req_t            mem_req_o,
  input  rms_pkg::val_t                rd_a_i,
  input  rms_pkg::val_t                rd_b_i,
  input  logic                         clr_done_i
);
  import rms_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StUpdWr  = 3'd1;
  localparam logic [2:0] StUpdMin = 3'd2;
  localparam logic [2:0] StQryRd  = 3'd3;
  localparam logic [2:0] StQryMin = 3'd4;

  logic [2:0] state_q, state_d;
  node_t      k_q, k_d;
  val_t       cur_q, cur_d;
  idx_t       l_q, l_d, r_q, r_d;
  val_t       m_q, m_d;
  logic       take_a_q, take_a_d, take_b_q, take_b_d;
  logic       out_valid_q, out_valid_d;
  val_t       out_min_q, out_min_d;

  logic       in_fire;
  idx_t       lo, hi, r_dec;
  val_t       val_sat, cand_a, cand_b;

  assign in_ready_o = (state_q == StIdle) && clr_done_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign val_sat = (value_i > Sentinel) ? Sentinel : value_i;
  assign lo      = (32'(range_start_i) > Leaves) ? idx_t'(Leaves) : idx_t'(range_start_i);
  assign hi      = (32'(range_end_i) > Leaves) ? idx_t'(Leaves) : idx_t'(range_end_i);
  assign r_dec   = r_q - idx_t'(1);
  assign cand_a  = take_a_q ? rd_a_i : Sentinel;
  assign cand_b  = take_b_q ? rd_b_i : Sentinel;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cur_d       = cur_q;
    l_d         = l_q;
    r_d         = r_q;
    m_d         = m_q;
    take_a_d    = take_a_q;
    take_b_d    = take_b_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_min_d   = out_min_q;

    mem_req_o.we      = 1'b0;
    mem_req_o.waddr   = k_q;
    mem_req_o.wdata   = cur_q;
    mem_req_o.raddr_a = k_q ^ node_t'(1);
    mem_req_o.raddr_b = r_dec[NodeBits-1:0];

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (!mode_i) begin
            // positions past the leaf count are dropped
            if (32'(position_i) < Leaves) begin
              k_d     = node_t'(LeafBase + 32'(position_i));
              cur_d   = val_sat;
              state_d = StUpdWr;
            end
          end else begin
            l_d     = lo + idx_t'(LeafBase);
            r_d     = hi + idx_t'(LeafBase);
            m_d     = Sentinel;
            state_d = StQryRd;
          end
        end
      end
      StUpdWr: begin
        // write this node, fetch its sibling for the parent
        mem_req_o.we = 1'b1;
        if (k_q == node_t'(1)) begin
          state_d = StIdle;
        end else begin
          state_d = StUpdMin;
        end
      end
      StUpdMin: begin
        cur_d   = min_val(cur_q, rd_a_i);
        k_d     = k_q >> 1;
        state_d = StUpdWr;
      end
      StQryRd: begin
        mem_req_o.raddr_a = l_q[NodeBits-1:0];
        if (l_q < r_q) begin
          take_a_d = l_q[0];
          take_b_d = r_q[0];
          l_d      = (l_q + idx_t'(l_q[0])) >> 1;
          r_d      = r_q >> 1;
          state_d  = StQryMin;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_min_d   = m_q;
          state_d     = StIdle;
        end
      end
      StQryMin: begin
        m_d     = min_val(m_q, min_val(cand_a, cand_b));
        state_d = StQryRd;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    cur_q     <= cur_d;
    l_q       <= l_d;
    r_q       <= r_d;
    m_q       <= m_d;
    take_a_q  <= take_a_d;
    take_b_q  <= take_b_d;
    out_min_q <= out_min_d;
  end

  assign out_valid_o = out_valid_q;
  assign minimum_o   = out_min_q;

endmodule

FILE: rtl/range_min_segment_tree.sv
// Range-minimum segment tree over 1024 leaves, all nodes held in one memory with
// a write port and two registered read ports. After reset a clearing pass
// writes the sentinel 1e15 to all 2048 node entries before the first transfer
// is taken. An update (mode 0) writes the leaf while reading its sibling, then
// takes the min and writes it to the parent, level by level up to the root,
// giving no result. A query (mode 1) reads and folds in the nodes at each level
// visited, then waits if needed for the result register to drain; an empty span
// visits no level and returns the sentinel. One item is in work at a time.
module range_min_segment_tree (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [rms_pkg::PosW-1:0]   position_i,
  input  logic [rms_pkg::ValW-1:0]   value_i,
  input  logic [rms_pkg::RangeW-1:0] range_start_i,
  input  logic [rms_pkg::RangeW-1:0] range_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rms_pkg::ValW-1:0]   minimum_o
);
  import rms_pkg::*;

  mem_req_t mem_req;
  val_t     rd_a, rd_b;
  logic     clr_done;

  rms_node_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_a_o     (rd_a),
    .rd_b_o     (rd_b),
    .clr_done_o (clr_done)
  );

  rms_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .minimum_o     (minimum_o),
    .mem_req_o     (mem_req),
    .rd_a_i        (rd_a),
    .rd_b_i        (rd_b),
    .clr_done_i    (clr_done)
  );

`ifndef SYNTHESIS
  a_no_transfer_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_clear_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done |=> clr_done)
    else $error("clearing pass restarted");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> minimum_o <= Sentinel)
    else $error("result above sentinel");

  a_no_write_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_done && mem_req.we) |-> mem_req.waddr != '0)
    else $error("write to unused node 0");
`endif

endmodule
